>>> rtl/core/length_prefixed_frame_splitter_core_assert.svh
// Assertion macros used by the checker file of the frame splitter core.
`ifndef LENGTH_PREFIXED_FRAME_SPLITTER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_SPLITTER_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is held low.
`define LPFS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LPFS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> rtl/core/lpfs_pkg.sv
// Types and constants of the length-prefixed frame splitter core.
package lpfs_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_KIND    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_LEN  = 2'd1;
  localparam logic [1:0] ERR_KIND = 2'd2;

  localparam logic [1:0] CFG_MAX_LEN   = 2'd0;
  localparam logic [1:0] CFG_KIND_LOW  = 2'd1;
  localparam logic [1:0] CFG_KIND_HIGH = 2'd2;

  localparam logic [31:0] MAX_LEN_RST   = 32'd1048576;
  localparam logic [7:0]  KIND_LOW_RST  = 8'd0;
  localparam logic [7:0]  KIND_HIGH_RST = 8'd255;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int BYTE_W    = 8;
  localparam int USER_W    = 11;

  typedef struct packed {
    logic [7:0] payload;
    logic [7:0] kind;
    logic       has_data;
    logic       last;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/core/lpfs_front.sv
// Front end: parses the header, checks length and kind, issues result requests.
module lpfs_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lpfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpfs_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lpfs_pkg::BYTE_W-1:0]         in_tdata,
  input  lpfs_pkg::q_stat_t                   q_stat,
  output logic                                push,
  output lpfs_pkg::res_t                      push_data
);
  import lpfs_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [23:0] len_r, len_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  cur_kind_r, cur_kind_nxt;
  logic        err_r, err_nxt;
  logic [31:0] max_len_r;
  logic [7:0]  kind_low_r;
  logic [7:0]  kind_high_r;

  logic        accept;
  logic [31:0] len_full;
  logic        len_bad;
  logic        kind_bad;
  logic        is_last;

  assign in_tready = err_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign len_full  = {len_r, in_tdata};
  assign len_bad   = (len_full == 32'd0) || (len_full > max_len_r);
  assign kind_bad  = (in_tdata < kind_low_r) || (in_tdata > kind_high_r);
  assign is_last   = (bytes_left_r <= 32'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LEN_RST;
      kind_low_r  <= KIND_LOW_RST;
      kind_high_r <= KIND_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LEN:   max_len_r   <= cfg_wdata;
        CFG_KIND_LOW:  kind_low_r  <= cfg_wdata[7:0];
        CFG_KIND_HIGH: kind_high_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_idx_r    <= 2'd0;
      len_r        <= 24'd0;
      bytes_left_r <= 32'd0;
      cur_kind_r   <= 8'd0;
      err_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      len_r        <= len_nxt;
      bytes_left_r <= bytes_left_nxt;
      cur_kind_r   <= cur_kind_nxt;
      err_r        <= err_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    len_nxt        = len_r;
    bytes_left_nxt = bytes_left_r;
    cur_kind_nxt   = cur_kind_r;
    err_nxt        = err_r;
    push           = 1'b0;
    push_data      = '{payload: 8'd0, kind: 8'd0, has_data: 1'b0, last: 1'b1, err: ERR_NONE};
    if (accept && !err_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_idx_r != 2'd3) begin
            hdr_idx_nxt = hdr_idx_r + 2'd1;
            len_nxt     = {len_r[15:0], in_tdata};
          end else begin
            hdr_idx_nxt = 2'd0;
            if (len_bad) begin
              err_nxt       = 1'b1;
              push          = 1'b1;
              push_data.err = ERR_LEN;
            end else begin
              bytes_left_nxt = len_full - 32'd1;
              phase_nxt      = PH_KIND;
            end
          end
        end
        PH_KIND: begin
          if (kind_bad) begin
            err_nxt        = 1'b1;
            push           = 1'b1;
            push_data.kind = in_tdata;
            push_data.err  = ERR_KIND;
          end else begin
            cur_kind_nxt = in_tdata;
            if (bytes_left_r == 32'd0) begin
              phase_nxt      = PH_HEADER;
              push           = 1'b1;
              push_data.kind = in_tdata;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          push               = 1'b1;
          push_data.payload  = in_tdata;
          push_data.kind     = cur_kind_r;
          push_data.has_data = 1'b1;
          push_data.last     = is_last;
          if (is_last) begin
            bytes_left_nxt = 32'd0;
            phase_nxt      = PH_HEADER;
          end else begin
            bytes_left_nxt = bytes_left_r - 32'd1;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/lpfs_queue.sv
// Result queue between the front end and the output stage.
module lpfs_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpfs_pkg::res_t     push_data,
  input  logic               pop,
  output lpfs_pkg::res_t     pop_data,
  output lpfs_pkg::q_stat_t  q_stat
);
  import lpfs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  res_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/lpfs_back.sv
// Output stage: takes requests from the queue into the result register.
module lpfs_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lpfs_pkg::q_stat_t                  q_stat,
  input  lpfs_pkg::res_t                     pop_data,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lpfs_pkg::BYTE_W-1:0]        out_tdata,
  output logic [lpfs_pkg::USER_W-1:0]        out_tuser,
  output logic                               out_tlast
);
  import lpfs_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign pop       = !q_stat.empty && (!valid_r || out_tready);
  assign valid_nxt = pop || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= pop_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.payload;
  assign out_tuser  = {res_r.err, res_r.has_data, res_r.kind};
  assign out_tlast  = res_r.last;

endmodule

>>> rtl/core/length_prefixed_frame_splitter_core.sv
// Top level of the length-prefixed frame splitter core.
//
// Input stream: one raw byte per request on in_tdata. Frames are a 4-byte
// big-endian length L, a kind byte, then L-1 payload bytes.
// Output stream: one request per payload byte; out_tuser carries the frame
// kind, a has-data flag and an error code, out_tlast marks the end of a frame.
// A frame with L=1 gives one request with has-data low and tlast high.
// A bad length or kind gives one error request, then all input is dropped
// (still accepted) until reset.
// Configuration: cfg_we with cfg_index selects max length, kind low, kind high;
// writes take effect at the next check that uses them.
// A result is written into the queue at the edge that takes its byte, and
// reaches out_tvalid through the output register.
// Throughput: one byte per cycle while in_tready is high, set by the parser in
// the front end and the single output register.
// Reset (rst_n low, synchronous) returns to header parsing and restores the
// register defaults. When out_tready is low the output register and the queue
// hold up to QUEUE_DEPTH + 1 requests, then in_tready drops until one drains.
module length_prefixed_frame_splitter_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lpfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpfs_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lpfs_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] stream_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lpfs_pkg::BYTE_W-1:0]        out_tdata,  // [7:0] payload_byte
  output logic [lpfs_pkg::USER_W-1:0]        out_tuser,  // [7:0] frame_kind, [8] has_data,
                                                         // [10:9] error_code
  output logic                               out_tlast
);
  import lpfs_pkg::*;

  q_stat_t q_stat;
  logic    push;
  res_t    push_data;
  logic    pop;
  res_t    pop_data;

  lpfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  lpfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  lpfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/core/lpfs_checker.sv
// Port-level checker of the frame splitter core and its bind.
`include "length_prefixed_frame_splitter_core_assert.svh"

module lpfs_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_we,
  input logic [lpfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [lpfs_pkg::CFG_W-1:0]         cfg_wdata,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [lpfs_pkg::BYTE_W-1:0]        in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [lpfs_pkg::BYTE_W-1:0]        out_tdata,
  input logic [lpfs_pkg::USER_W-1:0]        out_tuser,
  input logic                               out_tlast
);
  import lpfs_pkg::*;

  `LPFS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output request changed")
  `LPFS_ASSERT(a_data_no_err, clk, rst_n, out_tvalid && out_tuser[8] |-> out_tuser[10:9] == ERR_NONE, "data request carries an error code")
  `LPFS_ASSERT(a_nodata_last, clk, rst_n, out_tvalid && !out_tuser[8] |-> out_tlast && out_tdata == 8'd0, "request without data is not a zero last")
  `LPFS_ASSERT(a_err_code, clk, rst_n, out_tvalid |-> out_tuser[10:9] == ERR_NONE || out_tuser[10:9] == ERR_LEN || out_tuser[10:9] == ERR_KIND, "undefined error code")
  `LPFS_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind length_prefixed_frame_splitter_core lpfs_checker u_lpfs_checker (.*);

>>> tb/sv/length_prefixed_frame_splitter_core_tb.sv
// Self-checking testbench for the length-prefixed frame splitter core.
module length_prefixed_frame_splitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfs_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  class deframe_scoreboard;
    logic [31:0] max_len;
    logic [7:0]  kind_lo;
    logic [7:0]  kind_hi;
    phase_t      phase;
    logic [1:0]  hdr_idx;
    logic [31:0] len_acc;
    logic [31:0] remaining;
    logic [7:0]  kind_cur;
    bit          halted;
    res_t        frame_results[$];
    int          fails;

    function new();
      max_len   = MAX_LEN_RST;
      kind_lo   = KIND_LOW_RST;
      kind_hi   = KIND_HIGH_RST;
      phase     = PH_HEADER;
      hdr_idx   = '0;
      len_acc   = '0;
      remaining = '0;
      kind_cur  = '0;
      halted    = 1'b0;
      fails     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_MAX_LEN:   max_len = val;
        CFG_KIND_LOW:  kind_lo = val[7:0];
        CFG_KIND_HIGH: kind_hi = val[7:0];
        default: ;
      endcase
    endfunction

    function void queue_result(logic [7:0] data, logic [7:0] kind, logic has,
                               logic last, logic [1:0] err);
      res_t r;
      r.payload  = data;
      r.kind     = kind;
      r.has_data = has;
      r.last     = last;
      r.err      = err;
      frame_results.insert(frame_results.size(), r);
    endfunction

    function void take_stream_byte(logic [7:0] b);
      if (halted) return;
      case (phase)
        PH_HEADER: begin
          if (hdr_idx == 2'd0) len_acc = '0;
          len_acc |= {24'd0, b} << (8 * (3 - hdr_idx));
          if (hdr_idx != 2'd3) begin
            hdr_idx = hdr_idx + 2'd1;
          end else begin
            hdr_idx = '0;
            if (len_acc == 32'd0 || len_acc > max_len) begin
              halted = 1'b1;
              queue_result(8'd0, 8'd0, 1'b0, 1'b1, ERR_LEN);
            end else begin
              phase = PH_KIND;
            end
          end
        end
        PH_KIND: begin
          if (b < kind_lo || b > kind_hi) begin
            halted = 1'b1;
            queue_result(8'd0, b, 1'b0, 1'b1, ERR_KIND);
          end else begin
            kind_cur = b;
            if (len_acc == 32'd1) begin
              phase     = PH_HEADER;
              remaining = '0;
              queue_result(8'd0, b, 1'b0, 1'b1, ERR_NONE);
            end else begin
              remaining = len_acc - 32'd1;
              phase     = PH_PAYLOAD;
            end
          end
        end
        default: begin
          queue_result(b, kind_cur, 1'b1, remaining <= 32'd1, ERR_NONE);
          if (remaining <= 32'd1) begin
            remaining = '0;
            phase     = PH_HEADER;
          end else begin
            remaining = remaining - 32'd1;
          end
        end
      endcase
    endfunction

    function void compare_output(logic [7:0] data, logic [USER_W-1:0] user, logic last);
      res_t want;
      res_t got;
      got.payload  = data;
      got.kind     = user[7:0];
      got.has_data = user[8];
      got.last     = last;
      got.err      = user[10:9];
      if (frame_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: data %h kind %h has %b last %b err %0d",
                   got.payload, got.kind, got.has_data, got.last, got.err);
        return;
      end
      want = frame_results.pop_front();
      if (got.payload !== want.payload || got.kind !== want.kind ||
          got.has_data !== want.has_data || got.last !== want.last ||
          got.err !== want.err) begin
        fails++;
        if (fails <= 10)
          $display("bad result: exp data %h kind %h has %b last %b err %0d,",
                   want.payload, want.kind, want.has_data, want.last, want.err,
                   " got data %h kind %h has %b last %b err %0d",
                   got.payload, got.kind, got.has_data, got.last, got.err);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [1:0]        cfg_index  = '0;
  logic [31:0]       cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic [USER_W-1:0] out_tuser;
  logic              out_tlast;

  deframe_scoreboard sb = new();
  int idle_pct   = 30;
  int sent_bytes = 0;

  length_prefixed_frame_splitter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #4_000_000;
    $display("length_prefixed_frame_splitter_core: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  // result side: random backpressure, check every accepted request
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.compare_output(out_tdata, out_tuser, out_tlast);
      if (stall == 0) stall = pick_gap();
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_stream_byte(b);
    sent_bytes++;
  endtask

  task automatic send_header(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [31:0] len, input logic [7:0] kind);
    send_header(len);
    send_byte(kind);
    for (int i = 1; i < int'(len); i++) send_byte(8'($urandom));
  endtask

  task automatic random_frame();
    int cap;
    int len;
    int pick;
    logic [7:0] kind;
    cap  = (sb.max_len < 32'd48) ? int'(sb.max_len) : 48;
    pick = $urandom_range(9);
    if (pick == 0) len = 1;
    else if (pick == 1) len = cap;
    else len = $urandom_range(cap, 1);
    pick = $urandom_range(7);
    if (pick == 0) kind = sb.kind_lo;
    else if (pick == 1) kind = sb.kind_hi;
    else kind = 8'($urandom_range(sb.kind_hi, sb.kind_lo));
    send_frame(32'(len), kind);
  endtask

  task automatic fill(input int n);
    int start;
    start = sent_bytes;
    while (sent_bytes - start < n) random_frame();
  endtask

  // hold the sender until every predicted result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.frame_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [31:0] max_len, input logic [7:0] lo,
                           input logic [7:0] hi);
    write_reg(CFG_MAX_LEN, max_len);
    write_reg(CFG_KIND_LOW, {24'($urandom), lo});
    write_reg(CFG_KIND_HIGH, {24'($urandom), hi});
    write_reg(CFG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] bad_len;
    logic [31:0] max_sel;
    logic [7:0]  lo;
    logic [7:0]  hi;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(32'd1, 8'h00);
    send_frame(32'd3, 8'hFF);
    send_frame(32'd2, 8'h5A);
    fill(300);

    drain();
    lo = 8'($urandom);
    configure(32'd1, lo, lo);
    fill(250);

    drain();
    idle_pct = 0;
    configure(32'hFFFF_FFFF, 8'h00, 8'hFF);
    fill(400);

    drain();
    idle_pct = 50;
    lo = 8'($urandom_range(200));
    hi = lo + 8'($urandom_range(55));
    configure(32'($urandom_range(30, 2)), lo, hi);
    fill(400);

    drain();
    idle_pct = 60;
    lo = 8'($urandom);
    hi = 8'($urandom_range(255, lo));
    configure(32'($urandom_range(64, 31)), lo, hi);
    fill(400);

    // end with one protocol error; everything after it must be dropped
    drain();
    idle_pct = 30;
    max_sel = 32'($urandom_range(40, 1));
    case ($urandom_range(5))
      0: begin
        configure(max_sel, 8'h00, 8'hFF);
        repeat (3) random_frame();
        send_header(32'd0);
      end
      1: begin
        configure(max_sel, 8'h00, 8'hFF);
        repeat (3) random_frame();
        bad_len = $urandom_range(1) ? max_sel + 32'd1 : $urandom_range(32'hFFFF_FFFF, 41);
        send_header(bad_len);
      end
      2: begin
        configure(32'd0, 8'h00, 8'hFF);
        send_header($urandom);
      end
      3: begin
        lo = 8'($urandom_range(255, 1));
        configure(max_sel, lo, 8'hFF);
        repeat (3) random_frame();
        send_header(32'($urandom_range(max_sel, 1)));
        send_byte(8'($urandom_range(lo - 8'd1, 0)));
      end
      4: begin
        hi = 8'($urandom_range(254));
        configure(max_sel, 8'h00, hi);
        repeat (3) random_frame();
        send_header(32'($urandom_range(max_sel, 1)));
        send_byte(8'($urandom_range(255, hi + 8'd1)));
      end
      default: begin
        lo = 8'($urandom_range(255, 1));
        hi = 8'($urandom_range(lo - 8'd1, 0));
        configure(max_sel, lo, hi);
        send_header(32'($urandom_range(max_sel, 1)));
        send_byte(8'($urandom));
      end
    endcase
    repeat (40) send_byte(8'($urandom));
    drain();

    if (sb.fails == 0) begin
      $display("length_prefixed_frame_splitter_core: match");
    end else begin
      $display("length_prefixed_frame_splitter_core: mismatch");
    end
    $finish;
  end

endmodule
